[rtl/multitap_delay_diffuser_assert.svh]
// assertion macros for the rtl, compiled out for synthesis
`ifndef MULTITAP_DELAY_DIFFUSER_ASSERT_SVH
`define MULTITAP_DELAY_DIFFUSER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define MDD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("multitap delay diffuser assertion failed");
// expression must never be true outside reset
`define MDD_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("multitap delay diffuser forbidden condition");
`else
`define MDD_ASSERT(label, clk, rst, prop)
`define MDD_NEVER(label, clk, rst, expr)
`endif
`endif

[rtl/mdd_pkg.sv]
package mdd_pkg;

   localparam int LINE_DEPTH = 4096;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int MAX_TAPS   = 64;
   localparam int TAP_AW     = $clog2(MAX_TAPS);

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 18;
   localparam int DELAY_W  = 12;
   localparam int SLOT_W   = 6;
   localparam int CSR_W    = 7;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = SAMPLE_W + GAIN_W;
   localparam int ACC_W    = PROD_W + TAP_AW;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_TAP    = 1'b1;

   typedef logic [LINE_AW-1:0]         line_addr_type;
   typedef logic [LINE_AW:0]           fill_type;
   typedef logic [TAP_AW-1:0]          tap_addr_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [GAIN_W-1:0]   gain_type;
   typedef logic [DELAY_W-1:0]         delay_type;

   typedef struct packed {
      delay_type delay;
      gain_type  gain;
   } tap_entry_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic last;
      logic hit;
   } mac_ctl_type;

endpackage

[rtl/mdd_tap_mem.sv]
module mdd_tap_mem import mdd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  tap_addr_type  wr_addr,
   input  tap_entry_type wr_data,
   input  logic          rd_en,
   input  tap_addr_type  rd_addr,
   output tap_entry_type rd_data
);

   tap_entry_type       mem_ff [MAX_TAPS];
   logic [MAX_TAPS-1:0] valid_ff;
   tap_entry_type       rd_data_ff;
   logic                rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
   end

   // a slot never written reads as a zero tap
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

[rtl/mdd_line_mem.sv]
module mdd_line_mem import mdd_pkg::*; (
   input  logic          clock,
   input  logic          wr_en,
   input  line_addr_type wr_addr,
   input  sample_type    wr_data,
   input  logic          rd_en,
   input  line_addr_type rd_addr,
   output sample_type    rd_data
);

   sample_type mem_ff [LINE_DEPTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mdd_mac.sv]
module mdd_mac import mdd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mac_ctl_type ctl,
   input  sample_type  line_data,
   input  gain_type    gain,
   output logic        done,
   output sample_type  result
);

   localparam int ROUND_BIAS = 1 << (FRAC_W - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   sample_type                op_s;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   biased;
   logic signed [ACC_W-1:0]   shifted;
   logic                      valid3_ff;
   logic                      last3_ff;
   logic                      done_ff;

   // entries not yet written since reset count as silence
   always_comb begin
      op_s    = ctl.hit ? line_data : sample_type'(0);
      prod_in = op_s * gain;
      acc_in  = acc_ff + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         prod_ff <= prod_in;
      end
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (valid3_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         last3_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         valid3_ff <= ctl.valid;
         last3_ff  <= ctl.last;
         done_ff   <= valid3_ff & last3_ff;
      end
   end

   // round half up, then clamp to the sample range
   always_comb begin
      biased  = acc_ff + ACC_W'(ROUND_BIAS);
      shifted = biased >>> FRAC_W;
      if (shifted > SAT_HI) begin
         result = SAMPLE_W'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         result = SAMPLE_W'(SAT_LO);
      end else begin
         result = SAMPLE_W'(shifted);
      end
   end

   assign done = done_ff;

endmodule

[rtl/multitap_delay_diffuser.sv]
// channel | ports                         | direction | handshake
// req     | mode, sample_in, tap_slot ... | in        | req_valid / req_ready
// rsp     | sample_out                    | out       | rsp_valid / rsp_ready
// csr     | csr_wr_data                   | in        | csr_wr_en, no wait
// a tap word is written straight into the tap table; a sample word runs the clamped tap
// count, one tap per cycle through the tap table port and the delay line port
// the delay line has no clearing pass: a fill count masks entries not yet written
// reset is synchronous; the finished word sits in the rsp register while the next
// req word is taken, and a sample stalls only if that register is still full
`include "multitap_delay_diffuser_assert.svh"

module multitap_delay_diffuser import mdd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic [SLOT_W-1:0]        req_tap_slot,
   input  logic [DELAY_W-1:0]       req_tap_delay,
   input  logic signed [GAIN_W-1:0] req_tap_gain,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                     csr_wr_en,
   input  logic [CSR_W-1:0]         csr_wr_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_HOLD  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CSR_W-1:0] taps_ff;
   line_addr_type    wp_ff;
   fill_type         fill_ff;
   tap_addr_type     idx_ff, idx_in;
   tap_addr_type     last_idx_ff, last_idx_in;
   logic             s1_valid_ff;
   logic             s1_last_ff;
   logic             s2_valid_ff;
   logic             s2_last_ff;
   logic             s2_hit_ff;
   gain_type         s2_gain_ff;
   logic             rsp_valid_ff;
   sample_type       rsp_sample_out_ff;

   logic             accept;
   logic             sample_acc;
   logic             tap_acc;
   logic             slot_ok;
   logic             issue;
   logic             issue_last;
   logic             rsp_load;
   tap_entry_type    tap_wr;
   tap_entry_type    tap_rd;
   line_addr_type    line_rd_addr;
   logic             hit;
   sample_type       line_rd;
   mac_ctl_type      mac_ctl;
   logic             mac_done;
   sample_type       mac_result;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid & req_ready;
   assign sample_acc = accept & (req_mode == MODE_SAMPLE);
   assign slot_ok    = (32'(req_tap_slot) < MAX_TAPS);
   assign tap_acc    = accept & (req_mode == MODE_TAP) & slot_ok;
   assign issue      = (state_ff == S_RUN);
   assign issue_last = issue & (idx_ff == last_idx_ff);
   assign rsp_load   = (state_ff == S_HOLD) & (~rsp_valid_ff | rsp_ready);
   assign tap_wr     = '{delay: req_tap_delay, gain: req_tap_gain};

   // clamp the tap count to 1 .. MAX_TAPS
   always_comb begin
      if (taps_ff == '0) begin
         last_idx_in = '0;
      end else if (32'(taps_ff) > MAX_TAPS) begin
         last_idx_in = TAP_AW'(MAX_TAPS - 1);
      end else begin
         last_idx_in = TAP_AW'(taps_ff - CSR_W'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (sample_acc) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            idx_in = idx_ff + TAP_AW'(1);
            if (issue_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (mac_done) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         taps_ff      <= CSR_W'(1);
         wp_ff        <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         last_idx_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         s1_valid_ff <= issue;
         s1_last_ff  <= issue_last;
         s2_valid_ff <= s1_valid_ff;
         s2_last_ff  <= s1_last_ff;
         if (csr_wr_en) begin
            taps_ff <= csr_wr_data;
         end
         if (sample_acc) begin
            last_idx_ff <= last_idx_in;
            if (fill_ff != fill_type'(LINE_DEPTH)) begin
               fill_ff <= fill_ff + fill_type'(1);
            end
         end
         if (rsp_load) begin
            wp_ff        <= wp_ff - line_addr_type'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // tap position relative to the newest word, masked by what has been written
   always_comb begin
      line_rd_addr = wp_ff + line_addr_type'(tap_rd.delay);
      hit          = fill_type'(line_addr_type'(tap_rd.delay)) < fill_ff;
   end

   always_ff @(posedge clock) begin
      s2_hit_ff  <= hit;
      s2_gain_ff <= tap_rd.gain;
      if (rsp_load) begin
         rsp_sample_out_ff <= mac_result;
      end
   end

   assign mac_ctl = '{clear: sample_acc, valid: s2_valid_ff, last: s2_last_ff,
                      hit: s2_hit_ff};

   mdd_tap_mem u_tap_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tap_acc),
      .wr_addr (TAP_AW'(req_tap_slot)),
      .wr_data (tap_wr),
      .rd_en   (issue),
      .rd_addr (idx_ff),
      .rd_data (tap_rd)
   );

   mdd_line_mem u_line_mem (
      .clock   (clock),
      .wr_en   (sample_acc),
      .wr_addr (wp_ff),
      .wr_data (req_sample_in),
      .rd_en   (s1_valid_ff),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd)
   );

   mdd_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .line_data (line_rd),
      .gain      (s2_gain_ff),
      .done      (mac_done),
      .result    (mac_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   `MDD_ASSERT(a_done_in_drain, clock, reset, mac_done |-> (state_ff == S_DRAIN))
   `MDD_ASSERT(a_idle_pipe_empty, clock, reset, (state_ff == S_IDLE) |-> (!s1_valid_ff && !s2_valid_ff))
   `MDD_NEVER(a_fill_bound, clock, reset, fill_ff > fill_type'(LINE_DEPTH))
   `MDD_ASSERT(a_wp_on_result, clock, reset, (state_ff != S_HOLD) |=> $stable(wp_ff))

endmodule

[test/multitap_delay_diffuser_checker.sv]
`timescale 1ns / 1ps

module multitap_delay_diffuser_checker import mdd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_mode,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic [SLOT_W-1:0]          req_tap_slot,
   input  logic [DELAY_W-1:0]         req_tap_delay,
   input  logic signed [GAIN_W-1:0]   req_tap_gain,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_wr_en,
   input  logic [CSR_W-1:0]           csr_wr_data,
   output int                         pending,
   output int                         fail_count
);

   localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAT_LO = -(64'sd1 <<< (SAMPLE_W - 1));
   localparam longint HALF   = 64'sd1 <<< (FRAC_W - 1);

   sample_type       line_mem [LINE_DEPTH];
   line_addr_type    wr_ptr;
   delay_type        delay_tab [MAX_TAPS];
   gain_type         gain_tab [MAX_TAPS];
   logic [CSR_W-1:0] tap_count;
   sample_type       expected_out [$];
   int               mismatches;

   initial begin
      mismatches = 0;
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      fail_count = mismatches;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // store the sample, run the taps, round half up and saturate
   function automatic sample_type filter_sample(input sample_type s);
      int            n;
      longint        acc;
      longint        rounded;
      line_addr_type pos;
      n = (tap_count == 0) ? 1 : ((tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count));
      line_mem[wr_ptr] = s;
      acc = 0;
      for (int j = 0; j < n; j++) begin
         pos = wr_ptr + delay_tab[j];
         acc += longint'(line_mem[pos]) * longint'(gain_tab[j]);
      end
      rounded = (acc + HALF) >>> FRAC_W;
      wr_ptr = wr_ptr - 1'b1;
      if (rounded > SAT_HI)
         rounded = SAT_HI;
      if (rounded < SAT_LO)
         rounded = SAT_LO;
      return sample_type'(rounded);
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         for (int i = 0; i < LINE_DEPTH; i++)
            line_mem[i] = '0;
         for (int i = 0; i < MAX_TAPS; i++) begin
            delay_tab[i] = '0;
            gain_tab[i]  = '0;
         end
         wr_ptr    = '0;
         tap_count = 1;
         expected_out.delete();
      end else begin
         if (csr_wr_en)
            tap_count = csr_wr_data;
         if (req_valid && req_ready) begin
            if (req_mode == MODE_TAP) begin
               delay_tab[req_tap_slot] = req_tap_delay;
               gain_tab[req_tap_slot]  = req_tap_gain;
            end else begin
               expected_out.push_back(filter_sample(req_sample_in));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               report_mismatch($sformatf("unexpected word sample_out=%0d", rsp_sample_out));
            end else begin
               want = expected_out.pop_front();
               if (rsp_sample_out !== want)
                  report_mismatch($sformatf("sample_out got %0d want %0d",
                                            rsp_sample_out, want));
            end
         end
      end
      // nonblocking so the stimulus side reads a settled count
      pending <= expected_out.size();
   end

endmodule

[test/tb_multitap_delay_diffuser.sv]
`timescale 1ns / 1ps

module tb_multitap_delay_diffuser;
   import mdd_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_WORDS  = 230;

   typedef struct packed {
      logic         mode;
      sample_type   sample;
      tap_addr_type slot;
      delay_type    delay;
      gain_type     gain;
   } req_word_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_mode;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic [SLOT_W-1:0]          req_tap_slot;
   logic [DELAY_W-1:0]         req_tap_delay;
   logic signed [GAIN_W-1:0]   req_tap_gain;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_wr_en;
   logic [CSR_W-1:0]           csr_wr_data;

   logic         quiet;
   int           pending;
   int           fail_count;
   int           cycle_count;
   req_word_type directed [$];

   multitap_delay_diffuser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sample_in  (req_sample_in),
      .req_tap_slot   (req_tap_slot),
      .req_tap_delay  (req_tap_delay),
      .req_tap_gain   (req_tap_gain),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   multitap_delay_diffuser_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sample_in  (req_sample_in),
      .req_tap_slot   (req_tap_slot),
      .req_tap_delay  (req_tap_delay),
      .req_tap_gain   (req_tap_gain),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .pending        (pending),
      .fail_count     (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= quiet || ($urandom_range(99) >= 9);

   function automatic req_word_type make_word(input logic mode, input sample_type s,
                                              input tap_addr_type slot, input delay_type d,
                                              input gain_type g);
      req_word_type w;
      w.mode   = mode;
      w.sample = s;
      w.slot   = slot;
      w.delay  = d;
      w.gain   = g;
      return w;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      w.mode = ($urandom_range(99) < 15) ? MODE_TAP : MODE_SAMPLE;
      case ($urandom_range(9))
         0:       w.sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
         1:       w.sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
         2, 3:    w.sample = sample_type'(int'($urandom_range(2000)) - 1000);
         default: w.sample = sample_type'($urandom);
      endcase
      // mostly low slots so the writes land inside the summed range
      w.slot = $urandom_range(1) ? tap_addr_type'($urandom_range(7))
                                 : tap_addr_type'($urandom_range(MAX_TAPS - 1));
      case ($urandom_range(5))
         0:       w.delay = {DELAY_W{1'b1}};
         1:       w.delay = delay_type'($urandom);
         default: w.delay = delay_type'($urandom_range(31));
      endcase
      case ($urandom_range(9))
         0:          w.gain = {1'b0, {(GAIN_W-1){1'b1}}};
         1:          w.gain = {1'b1, {(GAIN_W-1){1'b0}}};
         2:          w.gain = '0;
         3, 4, 5:    w.gain = gain_type'(int'($urandom_range(8192)) - 4096);
         default:    w.gain = gain_type'($urandom);
      endcase
      return w;
   endfunction

   // valid stays up across back-to-back words; it only drops on a gap
   task automatic send_word(input req_word_type w);
      if (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < 40);
      end
      req_valid     <= 1'b1;
      req_mode      <= w.mode;
      req_sample_in <= w.sample;
      req_tap_slot  <= w.slot;
      req_tap_delay <= w.delay;
      req_tap_gain  <= w.gain;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tap_count(input logic [CSR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [CSR_W-1:0] settings [8];
      cycle_count   = 0;
      quiet         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_SAMPLE;
      req_sample_in = '0;
      req_tap_slot  = '0;
      req_tap_delay = '0;
      req_tap_gain  = '0;
      rsp_ready     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      settings = '{7'd64, 7'd0, 7'd127, 7'd100, 7'd17, 7'd64, 7'd2, 7'd0};
      settings[7] = CSR_W'($urandom_range(1, MAX_TAPS));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one tap at reset: zero gain, unit gain, extremes, rounding at the half
      directed.push_back(make_word(MODE_SAMPLE, 24'sh7fffff, 0, 0, 0));
      directed.push_back(make_word(MODE_TAP, 0, 0, 0, 18'sd65536));
      directed.push_back(make_word(MODE_SAMPLE, 24'sh800000, 0, 0, 0));
      directed.push_back(make_word(MODE_SAMPLE, 24'sh7fffff, 0, 0, 0));
      directed.push_back(make_word(MODE_TAP, 0, 0, 1, 18'sh1ffff));
      directed.push_back(make_word(MODE_SAMPLE, 24'sd1, 0, 0, 0));
      directed.push_back(make_word(MODE_TAP, 0, 0, 0, 18'sh20000));
      directed.push_back(make_word(MODE_SAMPLE, 24'sh800000, 0, 0, 0));
      directed.push_back(make_word(MODE_SAMPLE, 24'sh7fffff, 0, 0, 0));
      directed.push_back(make_word(MODE_TAP, 0, 6'd63, 12'hfff, 18'sd32768));
      directed.push_back(make_word(MODE_TAP, 0, 0, 0, 18'sd1));
      directed.push_back(make_word(MODE_SAMPLE, 24'sd32768, 0, 0, 0));
      directed.push_back(make_word(MODE_SAMPLE, -24'sd32768, 0, 0, 0));
      directed.push_back(make_word(MODE_SAMPLE, 24'sd98304, 0, 0, 0));
      directed.push_back(make_word(MODE_SAMPLE, -24'sd98304, 0, 0, 0));
      directed.push_back(make_word(MODE_TAP, 0, 0, 12'hfff, 18'sd65536));
      directed.push_back(make_word(MODE_SAMPLE, 24'sd12345, 0, 0, 0));
      foreach (directed[i])
         send_word(directed[i]);
      drain();

      foreach (settings[p]) begin
         write_tap_count(settings[p]);
         quiet = (p == 2);
         repeat (PHASE_WORDS)
            send_word(random_word());
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/mdd_pkg.sv
rtl/mdd_tap_mem.sv
rtl/mdd_line_mem.sv
rtl/mdd_mac.sv
rtl/multitap_delay_diffuser.sv
test/multitap_delay_diffuser_checker.sv
test/tb_multitap_delay_diffuser.sv
